>>> sv/icds_pkg.sv
// ----------------------------------------------------------------------------
// icds_pkg
// Types, widths and constants shared by the I2C clock divider search block.
// ----------------------------------------------------------------------------
package icds_pkg;

  localparam int CLK_W  = 28;  // input clock in hertz
  localparam int TGT_W  = 20;  // requested SCL rate
  localparam int TGTC_W = 19;  // clamped target, at most 384600
  localparam int DSR_W  = 25;  // widest divisor: 22 * target
  localparam int CAND_W = 24;  // base quotient and candidate
  localparam int DA_W   = 2;
  localparam int DB_W   = 6;
  localparam int CNT_W  = 5;   // divider step counter

  localparam logic [TGTC_W-1:0] TGT_CLAMP  = 19'd384600;
  localparam logic [TGT_W-1:0]  BAND_HI    = 20'd100000;
  localparam logic [TGT_W-1:0]  BAND_LO    = 20'd90000;
  localparam logic [TGTC_W-1:0] BAND_SET   = 19'd90000;
  localparam logic [4:0]        SCL_K      = 5'd22;
  localparam logic [CLK_W-1:0]  A_Q_MAX    = 28'd4;   // quotient above this gives A > 3
  localparam logic [CLK_W-1:0]  CLK_RESET  = 28'd111111111;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE_GO,
    S_BASE_WAIT,
    S_REM_GO,
    S_REM_WAIT,
    S_A_GO,
    S_A_WAIT,
    S_RATE_GO,
    S_RATE_WAIT,
    S_NEXT_B,
    S_CAND_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CLK_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

  // Clamp the request: cap at the fast-mode limit, pull the band just
  // above 90 kHz down to 90 kHz.
  function automatic logic [TGTC_W-1:0] clamp_target(input logic [TGT_W-1:0] tgt);
    logic [TGTC_W-1:0] res;
    if (tgt > {1'b0, TGT_CLAMP}) begin
      res = TGT_CLAMP;
    end else if (tgt <= BAND_HI && tgt > BAND_LO) begin
      res = BAND_SET;
    end else begin
      res = tgt[TGTC_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> sv/i2c_clock_divider_search.sv
// ----------------------------------------------------------------------------
// i2c_clock_divider_search
// Finds the two-stage SCL divider pair closest to a requested rate.
// ----------------------------------------------------------------------------
// Write the controller input clock in hertz through cfg_wr_en/cfg_wr_data
// while the block is idle; reset loads 111111111.
// Raise start with in_target_scl_hz; the request is taken when busy is low.
// busy stays high until the result has been shown. The result appears on
// out_divider_a, out_divider_b, out_pair_found and out_fail for exactly one
// cycle, marked by out_valid, and the receiver must take it then.
// A zero target reports in the cycle after the request. Otherwise every
// division runs on one shared restoring divider. Each B step runs one
// division when A would exceed 3 and two when the rate is computed, with
// at most two candidates of 64 B steps each. One request at a time.
// Reset returns the sequencer to idle and drops any request in progress.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search #(
  parameter int B_STEPS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [icds_pkg::CLK_W-1:0]     cfg_wr_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [icds_pkg::TGT_W-1:0]     in_target_scl_hz,
  output logic                           out_valid,
  output logic [icds_pkg::DA_W-1:0]      out_divider_a,
  output logic [icds_pkg::DB_W-1:0]      out_divider_b,
  output logic                           out_pair_found,
  output logic                           out_fail
);

  localparam logic [icds_pkg::DB_W-1:0] B_LAST = icds_pkg::DB_W'(B_STEPS - 1);

  icds_pkg::state_t               state_r, state_nxt;
  logic [icds_pkg::CLK_W-1:0]     clk_hz_r;
  logic [icds_pkg::TGT_W-1:0]     tgt_r, tgt_nxt;
  logic [icds_pkg::TGTC_W-1:0]    tgtc_r, tgtc_nxt;
  logic [icds_pkg::CAND_W-1:0]    base_r, base_nxt;
  logic [icds_pkg::CAND_W-1:0]    cand_r, cand_nxt;
  logic                           two_r, two_nxt;
  logic [icds_pkg::DA_W-1:0]      a_r, a_nxt;
  logic [icds_pkg::DB_W-1:0]      b_r, b_nxt;
  logic [icds_pkg::DA_W-1:0]      ca_r, ca_nxt;
  logic [icds_pkg::DB_W-1:0]      cb_r, cb_nxt;
  logic [icds_pkg::TGTC_W-1:0]    loop_err_r, loop_err_nxt;
  logic [icds_pkg::TGTC_W-1:0]    best_err_r, best_err_nxt;
  logic [icds_pkg::DA_W-1:0]      best_a_r, best_a_nxt;
  logic [icds_pkg::DB_W-1:0]      best_b_r, best_b_nxt;
  logic                           found_r, found_nxt;
  logic                           fail_r, fail_nxt;

  icds_pkg::div_req_t             div_req;
  icds_pkg::div_rsp_t             div_rsp;

  logic [2:0]                     a_p1;
  logic [6:0]                     b_p1;
  logic [9:0]                     ab;
  logic [12:0]                    rate_dsr;
  logic [icds_pkg::DSR_W-1:0]     tgt22;
  logic [icds_pkg::DSR_W-1:0]     tgtc22;
  logic [icds_pkg::CLK_W-1:0]     tgtc_ext;
  logic [icds_pkg::CLK_W-1:0]     err;
  logic [icds_pkg::CLK_W-1:0]     q;

  icds_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= icds_pkg::CLK_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  always_comb begin
    a_p1     = {1'b0, a_r} + 3'd1;
    b_p1     = {1'b0, b_r} + 7'd1;
    ab       = 10'(a_p1) * 10'(b_p1);
    rate_dsr = 13'(ab) * 13'(icds_pkg::SCL_K);
    tgt22    = icds_pkg::DSR_W'(tgt_r) * icds_pkg::DSR_W'(icds_pkg::SCL_K);
    tgtc22   = icds_pkg::DSR_W'(tgtc_r) * icds_pkg::DSR_W'(icds_pkg::SCL_K);
    tgtc_ext = icds_pkg::CLK_W'(tgtc_r);
    q        = div_rsp.quotient;
    err      = (q > tgtc_ext) ? (q - tgtc_ext) : (tgtc_ext - q);

    state_nxt    = state_r;
    tgt_nxt      = tgt_r;
    tgtc_nxt     = tgtc_r;
    base_nxt     = base_r;
    cand_nxt     = cand_r;
    two_nxt      = two_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    ca_nxt       = ca_r;
    cb_nxt       = cb_r;
    loop_err_nxt = loop_err_r;
    best_err_nxt = best_err_r;
    best_a_nxt   = best_a_r;
    best_b_nxt   = best_b_r;
    found_nxt    = found_r;
    fail_nxt     = fail_r;

    div_req.start    = 1'b0;
    div_req.dividend = clk_hz_r;
    div_req.divisor  = tgt22;

    case (state_r)
      icds_pkg::S_IDLE: begin
        if (start) begin
          tgt_nxt    = in_target_scl_hz;
          tgtc_nxt   = icds_pkg::clamp_target(in_target_scl_hz);
          best_a_nxt = '0;
          best_b_nxt = '0;
          found_nxt  = 1'b0;
          if (in_target_scl_hz == '0) begin
            fail_nxt  = 1'b1;
            state_nxt = icds_pkg::S_DONE;
          end else begin
            fail_nxt  = 1'b0;
            state_nxt = icds_pkg::S_BASE_GO;
          end
        end
      end
      icds_pkg::S_BASE_GO: begin
        div_req.start = 1'b1;
        state_nxt     = icds_pkg::S_BASE_WAIT;
      end
      icds_pkg::S_BASE_WAIT: begin
        if (div_rsp.done) begin
          base_nxt = q[icds_pkg::CAND_W-1:0];
          if (q == '0) begin
            fail_nxt  = 1'b1;
            state_nxt = icds_pkg::S_DONE;
          end else begin
            state_nxt = icds_pkg::S_REM_GO;
          end
        end
      end
      icds_pkg::S_REM_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = tgtc22;
        state_nxt       = icds_pkg::S_REM_WAIT;
      end
      icds_pkg::S_REM_WAIT: begin
        if (div_rsp.done) begin
          // a remainder in the clamped division adds base + 1 as a second candidate
          two_nxt      = (div_rsp.remainder != '0);
          cand_nxt     = base_r;
          b_nxt        = '0;
          loop_err_nxt = tgtc_r;
          best_err_nxt = tgtc_r;
          state_nxt    = icds_pkg::S_A_GO;
        end
      end
      icds_pkg::S_A_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = icds_pkg::CLK_W'(cand_r);
        div_req.divisor  = icds_pkg::DSR_W'(b_p1);
        state_nxt        = icds_pkg::S_A_WAIT;
      end
      icds_pkg::S_A_WAIT: begin
        if (div_rsp.done) begin
          if (q > icds_pkg::A_Q_MAX) begin
            state_nxt = icds_pkg::S_NEXT_B;
          end else begin
            a_nxt     = (q == '0) ? '0 : icds_pkg::DA_W'(q - 1'b1);
            state_nxt = icds_pkg::S_RATE_GO;
          end
        end
      end
      icds_pkg::S_RATE_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = icds_pkg::DSR_W'(rate_dsr);
        state_nxt       = icds_pkg::S_RATE_WAIT;
      end
      icds_pkg::S_RATE_WAIT: begin
        if (div_rsp.done) begin
          // strict compare keeps the earliest B on a tie
          if (icds_pkg::CLK_W'(loop_err_r) > err) begin
            loop_err_nxt = err[icds_pkg::TGTC_W-1:0];
            ca_nxt       = a_r;
            cb_nxt       = b_r;
          end
          state_nxt = icds_pkg::S_NEXT_B;
        end
      end
      icds_pkg::S_NEXT_B: begin
        if (b_r == B_LAST) begin
          state_nxt = icds_pkg::S_CAND_END;
        end else begin
          b_nxt     = b_r + 1'b1;
          state_nxt = icds_pkg::S_A_GO;
        end
      end
      icds_pkg::S_CAND_END: begin
        if (loop_err_r < best_err_r) begin
          best_err_nxt = loop_err_r;
          best_a_nxt   = ca_r;
          best_b_nxt   = cb_r;
          found_nxt    = 1'b1;
        end
        if (two_r && cand_r == base_r) begin
          cand_nxt     = base_r + 1'b1;
          b_nxt        = '0;
          loop_err_nxt = tgtc_r;
          state_nxt    = icds_pkg::S_A_GO;
        end else begin
          state_nxt = icds_pkg::S_DONE;
        end
      end
      icds_pkg::S_DONE: begin
        state_nxt = icds_pkg::S_IDLE;
      end
      default: begin
        state_nxt = icds_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icds_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    tgtc_r     <= tgtc_nxt;
    base_r     <= base_nxt;
    cand_r     <= cand_nxt;
    two_r      <= two_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    loop_err_r <= loop_err_nxt;
    best_err_r <= best_err_nxt;
    best_a_r   <= best_a_nxt;
    best_b_r   <= best_b_nxt;
    found_r    <= found_nxt;
    fail_r     <= fail_nxt;
  end

  assign busy           = (state_r != icds_pkg::S_IDLE);
  assign out_valid      = (state_r == icds_pkg::S_DONE);
  assign out_divider_a  = best_a_r;
  assign out_divider_b  = best_b_r;
  assign out_pair_found = found_r;
  assign out_fail       = fail_r;

endmodule

>>> sv/icds_divider.sv
// ----------------------------------------------------------------------------
// icds_divider
// Restoring integer divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icds_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  icds_pkg::div_req_t req,
  output icds_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [icds_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [icds_pkg::CLK_W-1:0]    dvd_r, dvd_nxt;
  logic [icds_pkg::DSR_W-1:0]    dsr_r, dsr_nxt;
  logic [icds_pkg::DSR_W-1:0]    rem_r, rem_nxt;
  logic [icds_pkg::DSR_W:0]      rem_sh;
  logic [icds_pkg::DSR_W:0]      diff;
  logic                          fits;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[icds_pkg::CLK_W-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    fits     = (rem_sh >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = icds_pkg::CNT_W'(icds_pkg::CLK_W);
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      rem_nxt = fits ? diff[icds_pkg::DSR_W-1:0] : rem_sh[icds_pkg::DSR_W-1:0];
      dvd_nxt = {dvd_r[icds_pkg::CLK_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == icds_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

>>> sv/icds_checker.sv
// ----------------------------------------------------------------------------
// icds_checker
// Port-level checks on request and result sequencing of the divider search.
// ----------------------------------------------------------------------------
module icds_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [icds_pkg::DA_W-1:0]  out_divider_a,
  input logic [icds_pkg::DB_W-1:0]  out_divider_b,
  input logic                       out_pair_found,
  input logic                       out_fail
);

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  // a result only shows while a request is open
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown with no open request");

  // one result per request, then back to idle
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result repeated or block not released");

  // a failed search carries no divider pair
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fail |-> !out_pair_found && out_divider_a == '0 && out_divider_b == '0)
    else $error("failed result carries a divider pair");

endmodule

bind i2c_clock_divider_search icds_checker u_icds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_divider_a  (out_divider_a),
  .out_divider_b  (out_divider_b),
  .out_pair_found (out_pair_found),
  .out_fail       (out_fail)
);

>>> bench/tb_i2c_clock_divider_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_clock_divider_search
// Self-checking bench for the I2C SCL divider pair search.
// ----------------------------------------------------------------------------
// A table of directed requests covers the target clamp, the band folded to
// 90 kHz, zero targets, clocks too slow to divide and the clock extremes.
// Random phases follow, each with its own input clock setting. Every
// accepted request is predicted in the bench, and each result strobe is
// compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_i2c_clock_divider_search;

  localparam int B_STEPS    = 64;
  localparam int N_PHASES   = 5;
  localparam int PHASE_REQS = 16;
  localparam int MAX_CYCLES = 6000000;
  localparam int N_PLAN     = 24;

  typedef struct packed {
    logic [icds_pkg::DA_W-1:0] a;
    logic [icds_pkg::DB_W-1:0] b;
    logic                      found;
    logic                      fail;
  } dividers_t;

  typedef struct packed {
    logic [icds_pkg::CLK_W-1:0] clk_hz;
    logic [icds_pkg::TGT_W-1:0] tgt;
    bit                         lit_ok;
    dividers_t                  lit;
  } plan_row_t;

  localparam dividers_t FAIL_ONLY  = '{a: '0, b: '0, found: 1'b0, fail: 1'b1};
  localparam dividers_t EXACT_UNIT = '{a: '0, b: '0, found: 1'b1, fail: 1'b0};
  localparam dividers_t NO_LIT     = '0;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [icds_pkg::CLK_W-1:0]    cfg_wr_data;
  logic                          start;
  logic                          busy;
  logic [icds_pkg::TGT_W-1:0]    in_target_scl_hz;
  logic                          out_valid;
  logic [icds_pkg::DA_W-1:0]     out_divider_a;
  logic [icds_pkg::DB_W-1:0]     out_divider_b;
  logic                          out_pair_found;
  logic                          out_fail;

  // literal expectation travelling with the request on the bus
  bit                            req_lit_ok;
  dividers_t                     req_lit;

  dividers_t                     pending_dividers[$];
  dividers_t                     got_dividers;
  dividers_t                     want_dividers;
  logic [icds_pkg::CLK_W-1:0]    model_clk_hz;
  logic [icds_pkg::CLK_W-1:0]    driven_clk_hz;
  logic                          busy_q;
  bit                            idle_on;
  int                            n_accepted;
  int                            n_results;
  int                            n_found;
  int                            n_failed;
  int                            n_errors;
  int                            n_clk_settings;
  int                            n_cycles;
  plan_row_t                     plan [0:N_PLAN-1];

  i2c_clock_divider_search #(
    .B_STEPS(B_STEPS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .start           (start),
    .busy            (busy),
    .in_target_scl_hz(in_target_scl_hz),
    .out_valid       (out_valid),
    .out_divider_a   (out_divider_a),
    .out_divider_b   (out_divider_b),
    .out_pair_found  (out_pair_found),
    .out_fail        (out_fail)
  );

  always #2 clk = ~clk;

  // Search the divider pair closest to the requested rate.
  function automatic dividers_t compute_dividers(
    input logic [icds_pkg::CLK_W-1:0] clk_hz,
    input logic [icds_pkg::TGT_W-1:0] tgt_hz
  );
    longint unsigned fin, tgt, k, base_q, last_q, cand, best_err, run_err;
    longint unsigned a_val, bs, rate_hz, err, ka, kb;
    dividers_t res;
    res = '0;
    fin = clk_hz;
    tgt = tgt_hz;
    k = icds_pkg::SCL_K;
    if (tgt == 0) begin
      res.fail = 1'b1;
      return res;
    end
    // base quotient uses the target before the clamp
    base_q = fin / (k * tgt);
    if (base_q == 0) begin
      res.fail = 1'b1;
      return res;
    end
    if (tgt > icds_pkg::TGT_CLAMP) begin
      tgt = icds_pkg::TGT_CLAMP;
    end else if (tgt <= icds_pkg::BAND_HI && tgt > icds_pkg::BAND_LO) begin
      tgt = icds_pkg::BAND_SET;
    end
    last_q = (fin % (k * tgt) != 0) ? base_q + 1 : base_q;
    best_err = tgt;
    for (cand = base_q; cand <= last_q; cand++) begin
      run_err = tgt;
      ka = 0;
      kb = 0;
      for (bs = 0; bs < B_STEPS; bs++) begin
        a_val = cand / (bs + 1);
        if (a_val != 0) a_val = a_val - 1;
        if (a_val <= 3) begin
          rate_hz = fin / (k * (a_val + 1) * (bs + 1));
          err = (rate_hz > tgt) ? rate_hz - tgt : tgt - rate_hz;
          // strict compare keeps the earliest B on a tie
          if (run_err > err) begin
            ka = a_val;
            kb = bs;
            run_err = err;
          end
        end
      end
      if (run_err < best_err) begin
        best_err = run_err;
        res.a = ka[icds_pkg::DA_W-1:0];
        res.b = kb[icds_pkg::DB_W-1:0];
        res.found = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [icds_pkg::TGT_W-1:0] random_target();
    logic [icds_pkg::TGT_W-1:0] t;
    case ($urandom_range(0, 9))
      0: t = '0;
      1: t = icds_pkg::TGT_W'($urandom());
      2: t = icds_pkg::TGT_W'($urandom_range(89990, 100010));
      3: t = icds_pkg::TGT_W'($urandom_range(384590, 384610));
      4: t = icds_pkg::TGT_W'($urandom_range(1, 20000));
      default: t = icds_pkg::TGT_W'($urandom_range(1, 400000));
    endcase
    return t;
  endfunction

  function automatic logic [icds_pkg::CLK_W-1:0] random_clock();
    logic [icds_pkg::CLK_W-1:0] c;
    case ($urandom_range(0, 5))
      0: c = 28'd250000000;
      1: c = icds_pkg::CLK_W'($urandom());
      2: c = icds_pkg::CLK_W'($urandom_range(1000000, 250000000));
      3: c = icds_pkg::CLK_W'($urandom_range(0, 5000000));
      4: c = 28'd50000000;
      default: c = icds_pkg::CLK_RESET;
    endcase
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(input logic [icds_pkg::TGT_W-1:0] tgt, input bit lit_ok,
                               input dividers_t lit);
    int gap;
    int seen;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_target_scl_hz <= tgt;
    req_lit_ok       <= lit_ok;
    req_lit          <= lit;
    start            <= 1'b1;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  // Write the input clock once every pending result has come back.
  task automatic set_input_clock(input logic [icds_pkg::CLK_W-1:0] hz);
    start <= 1'b0;
    @(negedge clk);
    while (pending_dividers.size() != 0 || busy_q) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    driven_clk_hz = hz;
    n_clk_settings++;
  endtask

  always @(posedge clk) begin
    busy_q = busy;
    if (rst_n) begin
      if (out_valid) begin
        got_dividers = '{a: out_divider_a, b: out_divider_b,
                         found: out_pair_found, fail: out_fail};
        n_results++;
        if (got_dividers.found === 1'b1) n_found++;
        if (got_dividers.fail === 1'b1) n_failed++;
        if (pending_dividers.size() == 0) begin
          if (n_errors < 10)
            $display("ERROR: result with nothing pending: a=%0d b=%0d found=%b fail=%b",
                     out_divider_a, out_divider_b, out_pair_found, out_fail);
          n_errors++;
        end else begin
          want_dividers = pending_dividers.pop_front();
          if (got_dividers.a !== want_dividers.a || got_dividers.b !== want_dividers.b ||
              got_dividers.found !== want_dividers.found ||
              got_dividers.fail !== want_dividers.fail) begin
            if (n_errors < 10) begin
              $display("ERROR: result %0d: expected a=%0d b=%0d found=%b fail=%b",
                       n_results, want_dividers.a, want_dividers.b, want_dividers.found,
                       want_dividers.fail);
              $display("       got a=%0d b=%0d found=%b fail=%b",
                       got_dividers.a, got_dividers.b, got_dividers.found,
                       got_dividers.fail);
            end
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_dividers.push_back(req_lit_ok ? req_lit
                                              : compute_dividers(model_clk_hz,
                                                                 in_target_scl_hz));
        n_accepted++;
      end
      if (cfg_wr_en) model_clk_hz = cfg_wr_data;
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d requests pending", n_cycles,
               pending_dividers.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    start            = 1'b0;
    in_target_scl_hz = '0;
    req_lit_ok       = 1'b0;
    req_lit          = NO_LIT;
    busy_q           = 1'b0;
    idle_on          = 1'b1;
    model_clk_hz     = icds_pkg::CLK_RESET;
    driven_clk_hz    = icds_pkg::CLK_RESET;
    n_accepted       = 0;
    n_results        = 0;
    n_found          = 0;
    n_failed         = 0;
    n_errors         = 0;
    n_clk_settings   = 0;
    n_cycles         = 0;

    plan = '{
      '{icds_pkg::CLK_RESET, 20'd0,       1'b1, FAIL_ONLY},
      '{icds_pkg::CLK_RESET, 20'd100000,  1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd90001,   1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd90000,   1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd100001,  1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd384600,  1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd384601,  1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd1000000, 1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'hFFFFF,   1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd1,       1'b0, NO_LIT},
      '{icds_pkg::CLK_RESET, 20'd100,     1'b0, NO_LIT},
      '{28'd0,               20'd100,     1'b1, FAIL_ONLY},
      '{28'd0,               20'hFFFFF,   1'b1, FAIL_ONLY},
      '{28'd21,              20'd1,       1'b1, FAIL_ONLY},
      '{28'd22,              20'd1,       1'b1, EXACT_UNIT},
      '{28'd23,              20'd1,       1'b0, NO_LIT},
      '{28'd250000000,       20'd1,       1'b0, NO_LIT},
      '{28'd250000000,       20'd100000,  1'b0, NO_LIT},
      '{28'd250000000,       20'd400000,  1'b0, NO_LIT},
      '{28'd250000000,       20'd1000000, 1'b0, NO_LIT},
      '{28'hFFFFFFF,         20'hFFFFF,   1'b0, NO_LIT},
      '{28'hFFFFFFF,         20'd50000,   1'b0, NO_LIT},
      '{28'hFFFFFFF,         20'd0,       1'b1, FAIL_ONLY},
      '{28'd1000000,         20'd5000,    1'b0, NO_LIT}
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_PLAN; i++) begin
      if (plan[i].clk_hz != driven_clk_hz) begin
        set_input_clock(plan[i].clk_hz);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      issue_request(plan[i].tgt, plan[i].lit_ok, plan[i].lit);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_input_clock(random_clock());
      // some phases run back to back with no gaps
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_REQS; k++) issue_request(random_target(), 1'b0, NO_LIT);
    end

    start <= 1'b0;
    while (pending_dividers.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);

    $display("covered %0d requests over %0d clock settings: %0d pairs found, %0d failures",
             n_accepted, n_clk_settings, n_found, n_failed);
    $display("%0d results checked, %0d mismatches, %0d cycles", n_results, n_errors,
             n_cycles);
    if (n_errors == 0 && pending_dividers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
sv/icds_pkg.sv
sv/icds_divider.sv
sv/i2c_clock_divider_search.sv
sv/icds_checker.sv
bench/tb_i2c_clock_divider_search.sv
